// File: src/integer_set_successor_macros.svh
// Assertion macros shared by the integer set successor checker
`ifndef INTEGER_SET_SUCCESSOR_MACROS_SVH
`define INTEGER_SET_SUCCESSOR_MACROS_SVH

// clocked check, masked while reset is asserted
`define ISS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ISS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/iss_pkg.sv
// Shared constants, codes and helpers for the integer set successor block
`default_nettype none

package iss_pkg;

	localparam int UNIVERSE_BITS_DEF = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	// index of the lowest set bit, zero for an empty word
	function automatic logic [5:0] lowest64(input logic [63:0] w);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (w[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/integer_set_successor.sv
// Top level of the integer set successor: three-level bitmap set in synchronous memory
//
// Input stream s_*: s_tuser holds the opcode (insert or successor query), s_tdata the
// 17-bit signed key. A query key of -1 asks for the minimum of the set.
// Output stream m_*: one word per input word. m_tdata holds the successor, m_tuser the
// found flag (bit 0) and the range error flag of an insert (bit 1).
// An insert finishes in ST_EVAL, which sees the reads issued at the accepting edge; a
// query finishes in ST_EVAL when the successor lies in the key's own leaf word, goes on
// to ST_LEAF when it is found through the group word, and on to ST_GRP and then ST_LEAF
// when the top bitmap must be searched. Each extra state is one dependent read of the
// leaf or group memory. One word is in flight at a time; the next waits for its result.
// After reset the block sweeps the leaf and group memories clear, one entry a cycle,
// over 2^(UNIVERSE_BITS-6) leaf entries (1024 by default), with s_tready low throughout.
// A finished result waits in a holding register while the output register is stalled;
// no new word is accepted until that result has moved to the output register.
`default_nettype none

module integer_set_successor #(
	parameter int UNIVERSE_BITS = iss_pkg::UNIVERSE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [16:0] key
	input  wire logic [0:0]  s_tuser,   // [0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] next_key
	output logic [1:0]       m_tuser    // [0] found, [1] range_error
);

	localparam int UNIV_SZ   = 1 << UNIVERSE_BITS;
	localparam int LEAF_CNT  = (UNIVERSE_BITS > 6) ? (1 << (UNIVERSE_BITS - 6)) : 1;
	localparam int LAW       = (UNIVERSE_BITS > 6) ? (UNIVERSE_BITS - 6) : 1;
	localparam int GROUP_CNT = (LEAF_CNT > 64) ? (LEAF_CNT / 64) : 1;
	localparam int GAW       = (LEAF_CNT > 64) ? (LAW - 6) : 1;
	localparam int XW        = (UNIVERSE_BITS > 17) ? UNIVERSE_BITS : 17;

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_EVAL = 6'b000100,
		ST_GRP  = 6'b001000,
		ST_LEAF = 6'b010000,
		ST_WAIT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [63:0] leaf_mem [LEAF_CNT];
	logic [63:0] grp_mem  [GROUP_CNT];
	logic [63:0] leaf_rd_q, grp_rd_q;
	logic [GROUP_CNT-1:0] top_q;

	logic [LAW-1:0] leaf_ra, leaf_wa, clr_q, li_q;
	logic [GAW-1:0] grp_ra, grp_wa, g_q;
	logic [63:0]    leaf_wd, grp_wd;
	logic           leaf_we, grp_we, top_set;

	logic           op_q, skip_q;
	logic [16:0]    pos_q;

	// input decode
	logic           in_op, in_neg, in_m1, in_skip;
	logic [16:0]    in_pos;
	logic [XW-1:0]  in_posx;
	logic [LAW-1:0] in_lw;
	logic [GAW-1:0] in_gi;

	always_comb begin
		in_op   = s_tuser[0];
		in_neg  = s_tdata[16];
		in_m1   = (s_tdata[16:0] == '1);
		in_pos  = (in_op == iss_pkg::OP_QUERY) ? (s_tdata[16:0] + 17'd1) : s_tdata[16:0];
		in_posx = XW'(in_pos);
		in_lw   = LAW'(in_posx >> 6);
		if (in_op == iss_pkg::OP_QUERY) begin
			in_skip = (in_neg && !in_m1) || (32'(in_pos) >= UNIV_SZ);
			in_gi   = GAW'(({1'b0, in_lw} + (LAW+1)'(1)) >> 6);
		end else begin
			in_skip = in_neg || (32'(in_pos) >= UNIV_SZ);
			in_gi   = GAW'(in_lw >> 6);
		end
	end

	// evaluation of the first reads
	logic [XW-1:0]   posx_q;
	logic [LAW-1:0]  lw_q;
	logic [5:0]      bit_q;
	logic [LAW:0]    gp, gs;
	logic            gi_ok, g_hit;
	logic [63:0]     leaf_m, grp_m;
	logic [LAW-1:0]  li_a, li_g;
	logic [GROUP_CNT-1:0] top_m;
	logic [GAW-1:0]  g_idx;

	always_comb begin
		posx_q = XW'(pos_q);
		lw_q   = LAW'(posx_q >> 6);
		bit_q  = posx_q[5:0];
		gp     = {1'b0, lw_q} + (LAW+1)'(1);
		gi_ok  = (gp >> 6) < (LAW+1)'(GROUP_CNT);
		gs     = (gp >> 6) + (LAW+1)'(1);
		leaf_m = leaf_rd_q & (~64'd0 << bit_q);
		grp_m  = gi_ok ? (grp_rd_q & (~64'd0 << 6'(gp))) : 64'd0;
		li_a   = LAW'({gp >> 6, iss_pkg::lowest64(grp_m)});
		li_g   = LAW'({g_q, iss_pkg::lowest64(grp_rd_q)});
		for (int i = 0; i < GROUP_CNT; i++) begin
			top_m[i] = top_q[i] && ((LAW+1)'(i) >= gs);
		end
		g_hit = |top_m;
		g_idx = '0;
		for (int i = GROUP_CNT - 1; i >= 0; i--) begin
			if (top_m[i]) begin
				g_idx = GAW'(i);
			end
		end
	end

	// read addresses
	always_comb begin
		leaf_ra = in_lw;
		grp_ra  = in_gi;
		unique case (state_q)
			ST_EVAL: begin
				leaf_ra = li_a;
				grp_ra  = g_idx;
			end
			ST_GRP: begin
				leaf_ra = li_g;
			end
			default: begin
			end
		endcase
	end

	// write port and result selection
	logic        fin, fin_found, fin_rerr, out_free, acc;
	logic [15:0] fin_next;

	always_comb begin
		leaf_we   = 1'b0;
		grp_we    = 1'b0;
		top_set   = 1'b0;
		leaf_wa   = lw_q;
		grp_wa    = GAW'(lw_q >> 6);
		leaf_wd   = leaf_rd_q | (64'd1 << bit_q);
		grp_wd    = grp_rd_q | (64'd1 << 6'(lw_q));
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_rerr  = 1'b0;
		fin_next  = '0;
		state_d   = state_q;
		out_free  = !m_tvalid || m_tready;
		acc       = s_tvalid && s_tready;
		unique case (state_q)
			ST_CLR: begin
				leaf_we = 1'b1;
				leaf_wa = clr_q;
				leaf_wd = '0;
				grp_we  = (32'(clr_q) < GROUP_CNT);
				grp_wa  = GAW'(clr_q);
				grp_wd  = '0;
				if (clr_q == LAW'(LEAF_CNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (op_q == iss_pkg::OP_INSERT) begin
					fin      = 1'b1;
					fin_rerr = skip_q;
					leaf_we  = !skip_q;
					grp_we   = !skip_q;
					top_set  = !skip_q;
				end else if (skip_q) begin
					fin = 1'b1;
				end else if (leaf_m != 64'd0) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_next  = 16'({lw_q, iss_pkg::lowest64(leaf_m)});
				end else if (grp_m != 64'd0) begin
					state_d = ST_LEAF;
				end else if (g_hit) begin
					state_d = ST_GRP;
				end else begin
					fin = 1'b1;
				end
			end
			ST_GRP: begin
				if (grp_rd_q == 64'd0) begin
					fin = 1'b1;
				end else begin
					state_d = ST_LEAF;
				end
			end
			ST_LEAF: begin
				fin       = 1'b1;
				fin_found = (leaf_rd_q != 64'd0);
				fin_next  = fin_found ? 16'({li_q, iss_pkg::lowest64(leaf_rd_q)}) : 16'd0;
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_WAIT;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// memories
	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_wa] <= leaf_wd;
		end
		leaf_rd_q <= leaf_mem[leaf_ra];
	end

	always_ff @(posedge clk) begin
		if (grp_we) begin
			grp_mem[grp_wa] <= grp_wd;
		end
		grp_rd_q <= grp_mem[grp_ra];
	end

	// control
	logic m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			top_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + LAW'(1);
			end
			if (top_set) begin
				top_q[GAW'(lw_q >> 6)] <= 1'b1;
			end
			if ((fin || state_q == ST_WAIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	logic        res_found_q, res_rerr_q;
	logic [15:0] res_next_q, m_tdata_q;
	logic [1:0]  m_tuser_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= in_op;
			skip_q <= in_skip;
			pos_q  <= in_pos;
		end
		if (state_q == ST_EVAL) begin
			g_q  <= g_idx;
			li_q <= li_a;
		end else if (state_q == ST_GRP) begin
			li_q <= li_g;
		end
		if (fin) begin
			res_found_q <= fin_found;
			res_rerr_q  <= fin_rerr;
			res_next_q  <= fin_next;
		end
		if (fin && out_free) begin
			m_tdata_q <= fin_next;
			m_tuser_q <= {fin_rerr, fin_found};
		end else if (state_q == ST_WAIT && out_free) begin
			m_tdata_q <= res_next_q;
			m_tuser_q <= {res_rerr_q, res_found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// File: src/iss_chk.sv
// Port checker for the integer set successor, bound to the top level
`default_nettype none
`include "integer_set_successor_macros.svh"

module iss_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	logic [18:0] m_word;

	assign m_word = {m_tvalid, m_tuser, m_tdata};

	`ISS_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> (!m_tvalid && !s_tready), "active during reset")
	`ISS_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> $stable(m_word), "stalled word changed")
	`ISS_ASSERT(a_miss_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0), "key without found")
	`ISS_ASSERT(a_one_flag, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "found and range error")
	`ISS_ASSERT(a_one_word, (s_tvalid && s_tready) |=> !s_tready, "second word taken at once")

endmodule

bind integer_set_successor iss_chk u_iss_chk (.*);

`default_nettype wire
